// ----- rtl/vad_pkg.sv -----
package vad_pkg;

   // Declaration type codes
   typedef enum logic [4:0] {
      TYPE_FLOAT1    = 5'd0,
      TYPE_FLOAT2    = 5'd1,
      TYPE_FLOAT3    = 5'd2,
      TYPE_FLOAT4    = 5'd3,
      TYPE_D3DCOLOR  = 5'd4,
      TYPE_UBYTE4    = 5'd5,
      TYPE_SHORT2    = 5'd6,
      TYPE_SHORT4    = 5'd7,
      TYPE_UBYTE4N   = 5'd8,
      TYPE_SHORT2N   = 5'd9,
      TYPE_SHORT4N   = 5'd10,
      TYPE_USHORT2N  = 5'd11,
      TYPE_USHORT4N  = 5'd12,
      TYPE_UDEC3     = 5'd13,
      TYPE_DEC3N     = 5'd14,
      TYPE_FLOAT16_2 = 5'd15,
      TYPE_FLOAT16_4 = 5'd16
   } elem_type_type;

   // Single-precision scale factor: biased exponent and mantissa with hidden bit
   typedef struct packed {
      logic [7:0]  exp;
      logic [23:0] mant;
   } scale_type;

   localparam scale_type SCALE_ONE   = '{exp: 8'd127, mant: 24'h800000};
   localparam scale_type SCALE_255   = '{exp: 8'd119, mant: 24'h808081};
   localparam scale_type SCALE_32767 = '{exp: 8'd112, mant: 24'h800100};
   localparam scale_type SCALE_65535 = '{exp: 8'd111, mant: 24'h800080};

   localparam logic [31:0] ONE_BITS       = 32'h3F800000;
   localparam logic [30:0] DEC3N_MIN_MAG  = 31'h3F804020;  // 512/511
   localparam logic [7:0]  HALF_EXP_BIAS  = 8'd112;

   function automatic logic [3:0] lead_zeros16(input logic [15:0] v);
      logic [3:0] n;
      logic       found;
      n     = 4'd0;
      found = 1'b0;
      for (int i = 15; i >= 0; i--) begin
         if (!found && v[i]) begin
            found = 1'b1;
            n     = 4'(15 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic       sign;
      logic [4:0] e;
      logic [9:0] m;
      logic [3:0] k;
      logic [3:0] sh;
      logic [10:0] mn;
      sign = h[15];
      e    = h[14:10];
      m    = h[9:0];
      k    = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) k = 4'(i);
      end
      sh = 4'd10 - k;
      mn = {1'b0, m} << sh;
      if (e == 5'd0) begin
         if (m == 10'd0) return {sign, 31'd0};
         return {sign, 8'(8'd103 + {4'd0, k}), mn[9:0], 13'd0};
      end
      if (e == 5'h1F) return {sign, 8'hFF, m, 13'd0};
      return {sign, 8'({3'd0, e} + HALF_EXP_BIAS), m, 13'd0};
   endfunction

   // Correctly rounded two's complement 10-bit code divided by 511.
   // a/511 for 0 < a < 511 is the 9-bit pattern of a repeated forever, so
   // the remainder past the guard bit is never zero and never a tie.
   function automatic logic [31:0] dec3n_single(input logic [9:0] u);
      logic        sign;
      logic [9:0]  a;
      logic [8:0]  a9;
      logic [3:0]  lz;
      logic [44:0] f;
      logic [22:0] mant;
      logic        g;
      logic [7:0]  ex;
      sign = u[9];
      a    = sign ? 10'(-u) : u;
      a9   = a[8:0];
      lz   = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (a9[i]) lz = 4'(8 - i);
      end
      f    = {5{a9}} << lz;
      mant = f[43:21];
      g    = f[20];
      ex   = 8'(8'd126 - {4'd0, lz});
      if (a == 10'd0) return 32'd0;
      if (a == 10'd511) return {sign, ONE_BITS[30:0]};
      if (a == 10'd512) return {sign, DEC3N_MIN_MAG};
      return {sign, 31'({ex, mant} + 31'(g))};
   endfunction

endpackage

// ----- rtl/vad_req_if.sv -----
interface vad_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  elem_type;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [31:0] word2;
   logic [31:0] word3;

   modport source (output valid, elem_type, word0, word1, word2, word3, input ready);
   modport sink   (input valid, elem_type, word0, word1, word2, word3, output ready);
endinterface

interface vad_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] comp_x;
   logic [31:0] comp_y;
   logic [31:0] comp_z;
   logic [31:0] comp_w;
   logic [4:0]  size_bytes;

   modport source (output valid, comp_x, comp_y, comp_z, comp_w, size_bytes, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, size_bytes, output ready);
endinterface

// ----- rtl/vad_scale_mul.sv -----
module vad_scale_mul
   import vad_pkg::*;
(
   input  logic        sign,
   input  logic [15:0] mag,
   input  scale_type   scale,
   output logic [31:0] result
);

   logic [3:0]  lz;
   logic [15:0] vn;
   logic [39:0] prod;
   logic [22:0] mant;
   logic        guard;
   logic        sticky;
   logic [8:0]  ex;
   logic        up;

   always_comb begin
      lz   = lead_zeros16(mag);
      vn   = mag << lz;
      prod = {24'd0, vn} * {16'd0, scale.mant};
      if (prod[39]) begin
         mant   = prod[38:16];
         guard  = prod[15];
         sticky = |prod[14:0];
         ex     = {1'b0, scale.exp} + 9'd16 - {5'd0, lz};
      end else begin
         mant   = prod[37:15];
         guard  = prod[14];
         sticky = |prod[13:0];
         ex     = {1'b0, scale.exp} + 9'd15 - {5'd0, lz};
      end
      // round to nearest even; a carry out of the mantissa bumps the exponent
      up = guard & (sticky | mant[0]);
      if (mag == 16'd0)
         result = 32'd0;
      else
         result = {sign, 31'({ex[7:0], mant} + 31'(up))};
   end

endmodule

// ----- rtl/vertex_attribute_decode.sv -----
// Vertex attribute decode.
// Takes one packed vertex attribute per transfer on req_if: a declaration
// type code and four big-endian words holding bytes 0-15 of the element.
// Gives one transfer on rsp_if per input: four single-precision components
// (missing ones default to 0, 0, 0, 1) and the element size in bytes, which
// is 0 for an unknown type.
// Structure: an input register and a result register enclose the decode
// logic, and rsp_if.valid is driven by the result register.
// Throughput: one attribute per cycle while rsp_if.ready is high. The critical
// path is the 16 x 24 multiply and rounding add in each of the four component lanes.
// Reset (synchronous, active high) empties both stages; nothing else is kept.
// When the receiver stalls, the result register holds and the input stage
// still takes a transfer while it is empty, so two items are held before
// req_if.ready drops.
module vertex_attribute_decode
   import vad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   vad_req_if.sink       req_if,
   vad_rsp_if.source     rsp_if
);

   // input stage
   logic          in_valid_ff;
   logic [4:0]    type_ff;
   logic [31:0]   word_ff [4];

   // result stage
   logic          out_valid_ff;
   logic [31:0]   comp_ff [4];
   logic [4:0]    size_ff;

   logic          out_advance;
   logic          in_advance;

   logic [31:0]   comp_in [4];
   logic [4:0]    size_in;

   logic          lane_sign [4];
   logic [15:0]   lane_mag  [4];
   scale_type     lane_scale;
   logic [31:0]   lane_prod [4];
   logic [15:0]   half_w    [4];

   // advance the result stage when it is empty or being taken
   assign out_advance   = !out_valid_ff || rsp_if.ready;
   assign in_advance    = !in_valid_ff || out_advance;
   assign req_if.ready  = in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_advance) in_valid_ff <= req_if.valid;
         if (out_advance) out_valid_ff <= in_valid_ff;
      end
      if (in_advance && req_if.valid) begin
         type_ff    <= req_if.elem_type;
         word_ff[0] <= req_if.word0;
         word_ff[1] <= req_if.word1;
         word_ff[2] <= req_if.word2;
         word_ff[3] <= req_if.word3;
      end
      if (out_advance && in_valid_ff) begin
         for (int i = 0; i < 4; i++) comp_ff[i] <= comp_in[i];
         size_ff <= size_in;
      end
   end

   // 16-bit halves in byte order: offset 0, 2, 4, 6
   assign half_w[0] = word_ff[0][31:16];
   assign half_w[1] = word_ff[0][15:0];
   assign half_w[2] = word_ff[1][31:16];
   assign half_w[3] = word_ff[1][15:0];

   // select integer operand and scale for each lane
   always_comb begin
      lane_scale = SCALE_ONE;
      for (int i = 0; i < 4; i++) begin
         lane_sign[i] = 1'b0;
         lane_mag[i]  = 16'd0;
      end
      case (elem_type_type'(type_ff))
         TYPE_D3DCOLOR, TYPE_UBYTE4, TYPE_UBYTE4N: begin
            for (int i = 0; i < 4; i++) lane_mag[i] = {8'd0, word_ff[0][8*i +: 8]};
            if (elem_type_type'(type_ff) != TYPE_UBYTE4) lane_scale = SCALE_255;
         end
         TYPE_SHORT2, TYPE_SHORT4, TYPE_SHORT2N, TYPE_SHORT4N: begin
            for (int i = 0; i < 4; i++) begin
               lane_sign[i] = half_w[i][15];
               lane_mag[i]  = half_w[i][15] ? 16'(-half_w[i]) : half_w[i];
            end
            if (elem_type_type'(type_ff) == TYPE_SHORT2N ||
                elem_type_type'(type_ff) == TYPE_SHORT4N)
               lane_scale = SCALE_32767;
         end
         TYPE_USHORT2N, TYPE_USHORT4N: begin
            for (int i = 0; i < 4; i++) lane_mag[i] = half_w[i];
            lane_scale = SCALE_65535;
         end
         TYPE_UDEC3: begin
            for (int i = 0; i < 3; i++) lane_mag[i] = {6'd0, word_ff[0][10*i +: 10]};
         end
         default: begin
         end
      endcase
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      vad_scale_mul u_mul (
         .sign   (lane_sign[g]),
         .mag    (lane_mag[g]),
         .scale  (lane_scale),
         .result (lane_prod[g])
      );
   end

   // pick each component; untouched ones keep the default
   always_comb begin
      comp_in[0] = 32'd0;
      comp_in[1] = 32'd0;
      comp_in[2] = 32'd0;
      comp_in[3] = ONE_BITS;
      size_in    = 5'd0;
      case (elem_type_type'(type_ff))
         TYPE_FLOAT1: begin
            comp_in[0] = word_ff[0];
            size_in    = 5'd4;
         end
         TYPE_FLOAT2: begin
            for (int i = 0; i < 2; i++) comp_in[i] = word_ff[i];
            size_in = 5'd8;
         end
         TYPE_FLOAT3: begin
            for (int i = 0; i < 3; i++) comp_in[i] = word_ff[i];
            size_in = 5'd12;
         end
         TYPE_FLOAT4: begin
            for (int i = 0; i < 4; i++) comp_in[i] = word_ff[i];
            size_in = 5'd16;
         end
         TYPE_D3DCOLOR, TYPE_UBYTE4, TYPE_UBYTE4N, TYPE_SHORT4N: begin
            for (int i = 0; i < 4; i++) comp_in[i] = lane_prod[i];
            size_in = (elem_type_type'(type_ff) == TYPE_SHORT4N) ? 5'd8 : 5'd4;
         end
         TYPE_SHORT4, TYPE_USHORT4N: begin
            for (int i = 0; i < 4; i++) comp_in[i] = lane_prod[i];
            size_in = 5'd8;
         end
         TYPE_SHORT2, TYPE_SHORT2N, TYPE_USHORT2N: begin
            for (int i = 0; i < 2; i++) comp_in[i] = lane_prod[i];
            size_in = 5'd4;
         end
         TYPE_UDEC3: begin
            for (int i = 0; i < 3; i++) comp_in[i] = lane_prod[i];
            size_in = 5'd4;
         end
         TYPE_DEC3N: begin
            for (int i = 0; i < 3; i++) comp_in[i] = dec3n_single(word_ff[0][10*i +: 10]);
            size_in = 5'd4;
         end
         TYPE_FLOAT16_2: begin
            for (int i = 0; i < 2; i++) comp_in[i] = half_to_single(half_w[i]);
            size_in = 5'd4;
         end
         TYPE_FLOAT16_4: begin
            for (int i = 0; i < 4; i++) comp_in[i] = half_to_single(half_w[i]);
            size_in = 5'd8;
         end
         default: begin
         end
      endcase
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.comp_x     = comp_ff[0];
   assign rsp_if.comp_y     = comp_ff[1];
   assign rsp_if.comp_z     = comp_ff[2];
   assign rsp_if.comp_w     = comp_ff[3];
   assign rsp_if.size_bytes = size_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import vad_pkg::*;

   localparam int          IDLE_PERCENT   = 8;
   localparam int          RANDOM_ITEMS   = 800;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          DRAIN_CYCLES   = 8;
   // single-precision scale factors the block multiplies by
   localparam logic [31:0] K_UNIT  = 32'h3F800000;
   localparam logic [31:0] K_255   = 32'h3B808081;
   localparam logic [31:0] K_32767 = 32'h38000100;
   localparam logic [31:0] K_65535 = 32'h37800080;
   localparam logic [4:0]  TYPE_UNUSED = 5'd17;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      logic [4:0]  size;
   } attrib_type;

   logic clock;
   logic reset;
   logic no_idle;
   int   mismatches = 0;
   int   stall_cycles = 0;

   attrib_type pending_attribs[$];

   vad_req_if req_if ();
   vad_rsp_if rsp_if ();

   vertex_attribute_decode u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Round q * 2^e2 to single precision, nearest even. Sticky marks a
   // nonzero remainder below q (used for the inexact divide by 511).
   function automatic logic [31:0] round_single(input bit sgn, input logic [63:0] q,
                                                input int e2, input bit sticky);
      int          p;
      int          sh;
      logic [63:0] m;
      logic [63:0] rem;
      logic [63:0] half;
      bit          up;
      if (q == 64'd0) return {sgn, 31'd0};
      p = 63;
      while (!q[p]) p--;
      if (p > 23) begin
         sh   = p - 23;
         m    = q >> sh;
         rem  = q & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         up   = (rem > half) || (rem == half && (sticky || m[0]));
         if (up) m = m + 64'd1;
         if (m[24]) begin
            m = m >> 1;
            p++;
         end
      end else begin
         m = q << (23 - p);
      end
      return {sgn, 8'(p + e2 + 127), m[22:0]};
   endfunction

   // Integer lane times a scale factor; unit scale gives the exact conversion
   function automatic logic [31:0] scale_lane(input logic [15:0] v, input bit is_signed,
                                              input logic [31:0] k);
      bit          neg;
      logic [16:0] mag;
      neg = is_signed && v[15];
      mag = neg ? 17'(-{1'b1, v}) : {1'b0, v};
      return round_single(neg, 64'(mag) * 64'({1'b1, k[22:0]}),
                          int'(k[30:23]) - 150, 1'b0);
   endfunction

   function automatic logic [31:0] div511_lane(input logic [9:0] code);
      bit          neg;
      logic [9:0]  mag;
      logic [63:0] num;
      neg = code[9];
      mag = neg ? 10'(-code) : code;
      num = 64'(mag) << 40;
      return round_single(neg, num / 64'd511, -40, (num % 64'd511) != 64'd0);
   endfunction

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [4:0] e;
      logic [9:0] m;
      logic [7:0] ex;
      e = h[14:10];
      m = h[9:0];
      if (e == 5'd0) begin
         if (m == 10'd0) return {h[15], 31'd0};
         ex = 8'd113;
         while (!m[9]) begin
            m  = m << 1;
            ex = ex - 8'd1;
         end
         // the leading one is now hidden
         m  = m << 1;
         ex = ex - 8'd1;
         return {h[15], ex, m, 13'd0};
      end
      if (e == 5'h1F) return {h[15], 8'hFF, m, 13'd0};
      return {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
   endfunction

   function automatic attrib_type decode_attrib(input logic [4:0] t, input logic [31:0] w0,
                                                input logic [31:0] w1, input logic [31:0] w2,
                                                input logic [31:0] w3);
      attrib_type  r;
      logic [31:0] k;
      r = '{x: 32'd0, y: 32'd0, z: 32'd0, w: K_UNIT, size: 5'd0};
      case (t)
         TYPE_FLOAT1: begin
            r.x = w0; r.size = 5'd4;
         end
         TYPE_FLOAT2: begin
            r.x = w0; r.y = w1; r.size = 5'd8;
         end
         TYPE_FLOAT3: begin
            r.x = w0; r.y = w1; r.z = w2; r.size = 5'd12;
         end
         TYPE_FLOAT4: begin
            r.x = w0; r.y = w1; r.z = w2; r.w = w3; r.size = 5'd16;
         end
         TYPE_D3DCOLOR, TYPE_UBYTE4, TYPE_UBYTE4N: begin
            k = (t == TYPE_UBYTE4) ? K_UNIT : K_255;
            r.x = scale_lane({8'd0, w0[7:0]}, 1'b0, k);
            r.y = scale_lane({8'd0, w0[15:8]}, 1'b0, k);
            r.z = scale_lane({8'd0, w0[23:16]}, 1'b0, k);
            r.w = scale_lane({8'd0, w0[31:24]}, 1'b0, k);
            r.size = 5'd4;
         end
         TYPE_SHORT2, TYPE_SHORT4, TYPE_SHORT2N, TYPE_SHORT4N,
         TYPE_USHORT2N, TYPE_USHORT4N: begin
            k = (t == TYPE_SHORT2 || t == TYPE_SHORT4) ? K_UNIT :
                (t == TYPE_USHORT2N || t == TYPE_USHORT4N) ? K_65535 : K_32767;
            r.x = scale_lane(w0[31:16], t != TYPE_USHORT2N && t != TYPE_USHORT4N, k);
            r.y = scale_lane(w0[15:0], t != TYPE_USHORT2N && t != TYPE_USHORT4N, k);
            r.size = 5'd4;
            if (t == TYPE_SHORT4 || t == TYPE_SHORT4N || t == TYPE_USHORT4N) begin
               r.z = scale_lane(w1[31:16], t != TYPE_USHORT4N, k);
               r.w = scale_lane(w1[15:0], t != TYPE_USHORT4N, k);
               r.size = 5'd8;
            end
         end
         TYPE_UDEC3: begin
            r.x = scale_lane({6'd0, w0[9:0]}, 1'b0, K_UNIT);
            r.y = scale_lane({6'd0, w0[19:10]}, 1'b0, K_UNIT);
            r.z = scale_lane({6'd0, w0[29:20]}, 1'b0, K_UNIT);
            r.size = 5'd4;
         end
         TYPE_DEC3N: begin
            r.x = div511_lane(w0[9:0]);
            r.y = div511_lane(w0[19:10]);
            r.z = div511_lane(w0[29:20]);
            r.size = 5'd4;
         end
         TYPE_FLOAT16_2: begin
            r.x = widen_half(w0[31:16]); r.y = widen_half(w0[15:0]); r.size = 5'd4;
         end
         TYPE_FLOAT16_4: begin
            r.x = widen_half(w0[31:16]); r.y = widen_half(w0[15:0]);
            r.z = widen_half(w1[31:16]); r.w = widen_half(w1[15:0]);
            r.size = 5'd8;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drive one attribute and hold it until the transfer; predict on acceptance
   task automatic send_attrib(input logic [4:0] t, input logic [31:0] w0,
                              input logic [31:0] w1, input logic [31:0] w2,
                              input logic [31:0] w3);
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.elem_type <= t;
      req_if.word0     <= w0;
      req_if.word1     <= w1;
      req_if.word2     <= w2;
      req_if.word3     <= w3;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_attribs.push_back(decode_attrib(t, w0, w1, w2, w3));
   endtask

   // Halves biased towards zero, denormal, inf and NaN exponents
   function automatic logic [15:0] pick_half();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(3))
         0: h[14:10] = 5'd0;
         1: h[14:10] = 5'h1F;
         default: ;
      endcase
      if ($urandom_range(7) == 0) h[9:0] = 10'd0;
      return h;
   endfunction

   // Words mixing plain random bits with half and extreme patterns
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return {16'h8000, 16'h7FFF};
         3, 4: return {pick_half(), pick_half()};
         default: return $urandom;
      endcase
   endfunction

   task automatic test_float_passthrough();
      send_attrib(TYPE_FLOAT1, 32'h3F80_0000, 32'hDEAD_BEEF, 32'h1, 32'h2);
      send_attrib(TYPE_FLOAT2, 32'h7F80_0000, 32'hFF80_0001, 32'h3, 32'h4);
      send_attrib(TYPE_FLOAT3, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h5);
      send_attrib(TYPE_FLOAT4, 32'hFFFF_FFFF, 32'h0, 32'hAAAA_5555, 32'h5555_AAAA);
   endtask

   task automatic test_byte_types();
      send_attrib(TYPE_D3DCOLOR, 32'hFF80_7F00, $urandom, $urandom, $urandom);
      send_attrib(TYPE_UBYTE4, 32'h00FF_01FE, $urandom, $urandom, $urandom);
      send_attrib(TYPE_UBYTE4N, 32'h0102_FEFF, $urandom, $urandom, $urandom);
   endtask

   task automatic test_short_types();
      send_attrib(TYPE_SHORT2, 32'h8000_7FFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_attrib(TYPE_SHORT4, 32'hFFFF_0001, 32'h8000_0000, 32'h0, 32'h0);
      send_attrib(TYPE_SHORT2N, 32'h8000_8001, 32'h1234_5678, 32'h0, 32'h0);
      send_attrib(TYPE_SHORT4N, 32'h7FFF_0001, 32'h8000_FFFF, 32'h0, 32'h0);
      send_attrib(TYPE_USHORT2N, 32'hFFFF_0001, 32'h0, 32'h0, 32'h0);
      send_attrib(TYPE_USHORT4N, 32'h8000_7FFF, 32'hFFFF_0000, 32'h0, 32'h0);
   endtask

   task automatic test_ten_bit_types();
      // raw codes include most negative, zero and largest; top two bits nonzero and ignored
      send_attrib(TYPE_UDEC3, {2'b11, 10'h3FF, 10'h000, 10'h200}, 32'h0, 32'h0, 32'h0);
      send_attrib(TYPE_DEC3N, {2'b10, 10'h200, 10'h1FF, 10'h000}, 32'h0, 32'h0, 32'h0);
      send_attrib(TYPE_DEC3N, {2'b01, 10'h201, 10'h3FF, 10'h001}, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_half_types();
      // signed zero, denormals, inf and NaN
      send_attrib(TYPE_FLOAT16_2, {16'h8000, 16'h0001}, 32'h0, 32'h0, 32'h0);
      send_attrib(TYPE_FLOAT16_4, {16'h03FF, 16'h7C00}, {16'hFE01, 16'h3C00}, 32'h0, 32'h0);
      send_attrib(TYPE_FLOAT16_4, {16'h0200, 16'h7BFF}, {16'h8001, 16'hFC00}, 32'h0, 32'h0);
   endtask

   task automatic test_unknown_types();
      send_attrib(TYPE_UNUSED, $urandom, $urandom, $urandom, $urandom);
      send_attrib(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_stream();
      logic [4:0] t;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a long stretch with back-to-back transfers on both sides
         no_idle = (i >= 300 && i < 450);
         t = ($urandom_range(15) == 0) ? 5'($urandom_range(31, 17))
                                       : 5'($urandom_range(16));
         send_attrib(t, pick_word(), pick_word(), pick_word(), pick_word());
      end
      no_idle = 1'b0;
      req_if.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side: check each transfer, then pick the next ready level
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      attrib_type got;
      attrib_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{x: rsp_if.comp_x, y: rsp_if.comp_y, z: rsp_if.comp_z,
                 w: rsp_if.comp_w, size: rsp_if.size_bytes};
         if (pending_attribs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: x=%h y=%h z=%h w=%h size=%0d",
                        got.x, got.y, got.z, got.w, got.size);
         end else begin
            want = pending_attribs.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected x=%h y=%h z=%h w=%h size=%0d, ",
                            "got x=%h y=%h z=%h w=%h size=%0d"},
                           want.x, want.y, want.z, want.w, want.size,
                           got.x, got.y, got.z, got.w, got.size);
            end
         end
      end
      rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      no_idle          = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.elem_type <= 5'd0;
      req_if.word0     <= 32'd0;
      req_if.word1     <= 32'd0;
      req_if.word2     <= 32'd0;
      req_if.word3     <= 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_float_passthrough();
      test_byte_types();
      test_short_types();
      test_ten_bit_types();
      test_half_types();
      test_unknown_types();
      test_random_stream();

      // drain, then allow the two pipeline stages to settle
      while (pending_attribs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_attribs.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
